@@ design/mrd_pkg.sv @@
// Shared types, constants and the CRC16 byte update for the Modbus RTU response deframer.
`timescale 1ns / 1ps
package mrd_pkg;

    localparam int BUFFER_BYTES_DEF = 64;

    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  FC_READ_HOLD  = 8'h03;
    localparam logic [7:0]  FC_READ_INPUT = 8'h04;
    localparam logic [7:0]  LEN_SHORT     = 8'd5;
    localparam logic [7:0]  LEN_DEFAULT   = 8'd8;
    localparam logic [7:0]  LEN_HEADER    = 8'd5;

    typedef enum logic {
        CMD_RX    = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] rx_byte;
        logic       overrun_error;
        logic       framing_error;
        logic       noise_error;
    } item_t;

    typedef struct packed {
        logic       byte_accepted;
        logic [5:0] byte_position;
        logic       frame_done;
        logic [6:0] frame_length;
        logic       crc_ok;
        logic [7:0] function_code;
        logic       line_error;
    } frame_res_t;

    typedef struct packed {
        logic [31:0] frame_total;
        logic [31:0] overrun_total;
        logic [31:0] framing_total;
        logic [31:0] noise_total;
    } totals_t;

    // Reflected CRC16 update over one byte, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ design/mrd_frame_ctl.sv @@
// Frame tracking: byte position, expected length, function code and running CRC.
`timescale 1ns / 1ps
module mrd_frame_ctl #(
    parameter int BUFFER_BYTES = mrd_pkg::BUFFER_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  mrd_pkg::item_t      item,
    output mrd_pkg::frame_res_t res
);
    import mrd_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       exp_len_reg, exp_len_next;
    logic [7:0]       func_reg, func_next;
    logic [15:0]      crc_reg, crc_next;

    logic             is_clear;
    logic             line_err;
    logic             rx_ok;
    logic [CNT_W-1:0] base_cnt;
    logic [15:0]      base_crc;
    logic [15:0]      crc_upd;
    logic [CNT_W-1:0] new_cnt;
    logic [7:0]       exp_upd;
    logic             reach;
    logic             done;

    always_comb begin
        is_clear = (item.command == CMD_CLEAR);
        line_err = !is_clear
                   && (item.overrun_error || item.framing_error || item.noise_error);
        rx_ok    = !is_clear && !line_err;

        // Wrap to position zero once the buffer is full.
        base_cnt = (count_reg == CNT_FULL) ? '0 : count_reg;
        base_crc = (count_reg == CNT_FULL) ? CRC_INIT : crc_reg;
        crc_upd  = crc16_byte(base_crc, item.rx_byte);
        new_cnt  = base_cnt + CNT_W'(1);

        func_next = func_reg;
        exp_upd   = exp_len_reg;
        if (rx_ok && new_cnt == CNT_TWO) begin
            func_next = item.rx_byte;
            if (item.rx_byte[7] || item.rx_byte == FC_READ_HOLD
                || item.rx_byte == FC_READ_INPUT) begin
                exp_upd = LEN_SHORT;
            end else begin
                exp_upd = LEN_DEFAULT;
            end
        end else if (new_cnt == CNT_THREE
                     && (func_reg == FC_READ_HOLD || func_reg == FC_READ_INPUT)) begin
            exp_upd = LEN_HEADER + item.rx_byte;
        end

        reach = ({1'b0, 8'(new_cnt)} >= {1'b0, exp_upd});
        done  = rx_ok && reach;

        if (rx_ok) begin
            exp_len_next = exp_upd;
            count_next   = done ? '0 : new_cnt;
            crc_next     = done ? CRC_INIT : crc_upd;
        end else begin
            exp_len_next = LEN_DEFAULT;
            count_next   = '0;
            crc_next     = CRC_INIT;
        end

        res.byte_accepted = rx_ok;
        res.byte_position = rx_ok ? 6'(base_cnt) : '0;
        res.frame_done    = done;
        res.frame_length  = done ? 7'(new_cnt) : '0;
        res.crc_ok        = done && (new_cnt >= CNT_TWO) && (crc_upd == 16'h0000);
        res.function_code = func_next;
        res.line_error    = line_err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            exp_len_reg <= LEN_DEFAULT;
            func_reg    <= '0;
            crc_reg     <= CRC_INIT;
        end else if (step) begin
            count_reg   <= count_next;
            exp_len_reg <= exp_len_next;
            func_reg    <= func_next;
            crc_reg     <= crc_next;
        end
    end

endmodule

@@ design/mrd_err_cnt.sv @@
// Wrapping totals of completed frames and of each line error kind.
`timescale 1ns / 1ps
module mrd_err_cnt (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  mrd_pkg::item_t   item,
    input  logic             frame_done,
    input  logic             line_error,
    output mrd_pkg::totals_t totals
);
    import mrd_pkg::*;

    totals_t tot_reg, tot_next;

    // Totals shown with an item already include that item.
    always_comb begin
        tot_next = tot_reg;
        if (step && frame_done) begin
            tot_next.frame_total = tot_reg.frame_total + 32'd1;
        end
        if (step && line_error && item.overrun_error) begin
            tot_next.overrun_total = tot_reg.overrun_total + 32'd1;
        end
        if (step && line_error && item.framing_error) begin
            tot_next.framing_total = tot_reg.framing_total + 32'd1;
        end
        if (step && line_error && item.noise_error) begin
            tot_next.noise_total = tot_reg.noise_total + 32'd1;
        end
        totals = tot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_reg <= '0;
        end else begin
            tot_reg <= tot_next;
        end
    end

endmodule

@@ design/modbus_rtu_response_deframer_top.sv @@
// Top level of the Modbus RTU response deframer: input register, frame logic, result register.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid / s_ready | command, rx_byte, overrun/framing/noise flags
//  m_      | out | m_valid / m_ready | accept/position, frame done/length/crc, totals
//
// One item per cycle sustained while m_ready stays high; an accepted item passes
// through the input register and then the result register before m_valid rises for it.
// An item is registered on entry, then the frame logic and CRC byte update run
// combinationally while it moves into the result register.
// Reset (aresetn low, synchronous) empties both registers and restores frame state.
// A stalled result holds in its register; one more item waits in the input register.
`timescale 1ns / 1ps
module modbus_rtu_response_deframer_top #(
    parameter int BUFFER_BYTES = mrd_pkg::BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_overrun_error,
    input  logic        s_framing_error,
    input  logic        s_noise_error,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_byte_accepted,
    output logic [5:0]  m_byte_position,
    output logic        m_frame_done,
    output logic [6:0]  m_frame_length,
    output logic        m_crc_ok,
    output logic        m_exception_reply,
    output logic [7:0]  m_function_code,
    output logic        m_line_error,
    output logic [31:0] m_frame_total,
    output logic [31:0] m_overrun_total,
    output logic [31:0] m_framing_total,
    output logic [31:0] m_noise_total
);
    import mrd_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    frame_res_t res_reg;
    totals_t    tot_reg;

    logic       advance;
    frame_res_t res;
    totals_t    totals;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mrd_frame_ctl #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_frame_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .res     (res)
    );

    mrd_err_cnt u_err_cnt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .frame_done (res.frame_done),
        .line_error (res.line_error),
        .totals     (totals)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command       <= cmd_t'(s_command);
            in_item_reg.rx_byte       <= s_rx_byte;
            in_item_reg.overrun_error <= s_overrun_error;
            in_item_reg.framing_error <= s_framing_error;
            in_item_reg.noise_error   <= s_noise_error;
        end
        if (advance) begin
            res_reg <= res;
            tot_reg <= totals;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_byte_accepted   = res_reg.byte_accepted;
    assign m_byte_position   = res_reg.byte_position;
    assign m_frame_done      = res_reg.frame_done;
    assign m_frame_length    = res_reg.frame_length;
    assign m_crc_ok          = res_reg.crc_ok;
    assign m_exception_reply = res_reg.function_code[7];
    assign m_function_code   = res_reg.function_code;
    assign m_line_error      = res_reg.line_error;
    assign m_frame_total     = tot_reg.frame_total;
    assign m_overrun_total   = tot_reg.overrun_total;
    assign m_framing_total   = tot_reg.framing_total;
    assign m_noise_total     = tot_reg.noise_total;

endmodule

@@ design/mrd_checker.sv @@
// Port-level checks on the deframer result channel, bound to the top level.
`timescale 1ns / 1ps
module mrd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_byte_accepted,
    input logic        m_frame_done,
    input logic        m_crc_ok,
    input logic        m_exception_reply,
    input logic [7:0]  m_function_code,
    input logic        m_line_error,
    input logic [31:0] m_frame_total
);

    // Hold a stalled result.
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_total))
        else $error("result changed while stalled");

    a_done_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_byte_accepted && !m_line_error)
        else $error("frame done without an accepted byte");

    a_error_drops_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_error |-> !m_byte_accepted && !m_frame_done && !m_crc_ok)
        else $error("line error item was not dropped");

    a_exc_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_exception_reply == m_function_code[7])
        else $error("exception flag disagrees with function code");

    // A completed frame bumps the frame total by one from the prior result.
    a_frame_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid && m_frame_done
        |-> m_frame_total == $past(m_frame_total) + 32'd1)
        else $error("frame total did not advance on a completed frame");

endmodule

bind modbus_rtu_response_deframer_top mrd_checker u_mrd_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_byte_accepted   (m_byte_accepted),
    .m_frame_done      (m_frame_done),
    .m_crc_ok          (m_crc_ok),
    .m_exception_reply (m_exception_reply),
    .m_function_code   (m_function_code),
    .m_line_error      (m_line_error),
    .m_frame_total     (m_frame_total)
);
